// File: hw/rtl/wbc_pkg.sv
// Shared constants, codes and types of the write-back block cache policy unit.
package wbc_pkg;

    // Defaults for the top-level parameters
    localparam int SLOTS_DEF      = 4;
    localparam int BLOCK_BITS_DEF = 32;

    // Fixed field widths on the stream ports
    localparam int OP_W     = 2;
    localparam int ADDR_W   = 32;
    localparam int CNT_W    = 16;
    localparam int KIND_W   = 2;
    localparam int SLOT_W   = 2;
    localparam int IN_DW    = 48;
    localparam int OUT_DW   = 40;
    localparam int OUT_PAD  = OUT_DW - SLOT_W - ADDR_W - 1;

    // Request opcodes
    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;
    localparam logic [OP_W-1:0] OP_BULK  = 2'd3;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_WB   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FILL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;

    // Flags returned by the shared comparator
    typedef struct packed {
        logic eq;
        logic lt;
    } t_cmp_res;

endpackage

// File: hw/rtl/wbc_cmp.sv
// Shared block-number comparator used by the search, scan, mark and fill-check steps of the sequencer.
module wbc_cmp #(
    parameter int W = wbc_pkg::BLOCK_BITS_DEF
) (
    input  logic [W-1:0]      i_a,
    input  logic [W-1:0]      i_b,
    output wbc_pkg::t_cmp_res o_res
);
    import wbc_pkg::*;

    // Compare one operand pair, unsigned
    always_comb begin
        o_res.eq = (i_a == i_b);
        o_res.lt = (i_a < i_b);
    end

endmodule

// File: hw/rtl/writeback_block_cache_policy_unit.sv
// Top level: tag, LRU order and write-back sequencer of a small block cache.
//
// Requests enter on the s_axis channel: tuser holds the opcode (read access,
// write access, flush, bulk write), tdata holds block_addr then block_count.
// Results leave on the m_axis channel: tuser holds the kind (write back,
// fill, done), tdata holds slot, target_block, already_dirty; tlast marks
// the done result that closes each request.
// One request is worked at a time; s_axis_tready is high only between
// requests. A single comparator is stepped over the slots, as follows:
//   hit: the used list is searched in order up to the matching position;
//   miss with a free slot: the used list is searched, then the block is inserted;
//   every write-back pass (flush, bulk write, miss on a full cache) runs
//   one full scan of the slots per written-back slot, plus one final
//   scan that finds no dirty slot; a bulk write of nonzero count then sets its mark.
// Results sit in an output register; when the receiver stalls the
// sequencer holds at its next result and resumes once the register frees.
// Reset empties the used list, clears all dirty bits and the
// highest-written mark; slot tags are not cleared and are only read once
// written. No clearing pass is needed after reset.
module writeback_block_cache_policy_unit #(
    parameter int SLOTS      = wbc_pkg::SLOTS_DEF,
    parameter int BLOCK_BITS = wbc_pkg::BLOCK_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // [31:0] block_addr, [47:32] block_count
    input  logic [wbc_pkg::IN_DW-1:0]   i_s_axis_tdata,
    // [1:0] opcode
    input  logic [wbc_pkg::OP_W-1:0]    i_s_axis_tuser,
    // result channel
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // [1:0] slot, [33:2] target_block, [34] already_dirty, [39:35] zero
    output logic [wbc_pkg::OUT_DW-1:0]  o_m_axis_tdata,
    // [1:0] kind
    output logic [wbc_pkg::KIND_W-1:0]  o_m_axis_tuser,
    output logic                        o_m_axis_tlast
);
    import wbc_pkg::*;

    localparam int SIW = $clog2(SLOTS);
    localparam int CW  = $clog2(SLOTS + 1);
    localparam int BB  = BLOCK_BITS;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SCAN,
        ST_WB_EMIT,
        ST_WB_MARK,
        ST_INSERT,
        ST_FILL_CHK,
        ST_DONE,
        ST_BULK_SUM,
        ST_BULK_MARK
    } t_state;

    t_state            r_state;
    logic [OP_W-1:0]   r_op;
    logic [BB-1:0]     r_addr;
    logic [CNT_W-1:0]  r_cnt;
    logic [CW-1:0]     r_idx;
    logic [CW-1:0]     r_used;
    logic [SIW-1:0]    r_slot;
    logic [SIW-1:0]    r_best;
    logic [BB-1:0]     r_best_tag;
    logic              r_found;
    logic [BB-1:0]     r_end;
    logic              r_mark_vld;
    logic [BB-1:0]     r_mark;
    logic [BB-1:0]     r_tag   [SLOTS];
    logic [SLOTS-1:0]  r_dirty;
    logic [SIW-1:0]    r_order [SLOTS];

    logic              r_ovalid;
    logic [KIND_W-1:0] r_okind;
    logic [SLOT_W-1:0] r_oslot;
    logic [ADDR_W-1:0] r_otgt;
    logic              r_oad;
    logic              r_olast;

    logic [SIW-1:0]    idx_s;
    logic [CW-1:0]     p_sel;
    logic [SIW-1:0]    order_at_p;
    logic [SIW-1:0]    tag_rd_idx;
    logic [BB-1:0]     tag_rd;
    logic [SIW-1:0]    rot_order [SLOTS];
    logic [BB-1:0]     cmp_a;
    logic [BB-1:0]     cmp_b;
    t_cmp_res          cmp_res;
    logic              o_free;
    logic              emit_now;
    logic              scan_take;
    logic              scan_last;
    logic [BB:0]       bulk_sum;
    logic [SLOTS-1:0]  order_mask;

    assign idx_s  = r_idx[SIW-1:0];
    assign o_free = !r_ovalid || i_m_axis_tready;

    // Select the single order read and the single tag read
    always_comb begin
        p_sel      = (r_state == ST_INSERT) ? r_used : r_idx;
        order_at_p = r_order[p_sel[SIW-1:0]];
        tag_rd_idx = (r_state == ST_SEARCH) ? order_at_p : idx_s;
        tag_rd     = r_tag[tag_rd_idx];
    end

    // Move the entry at p_sel to the front, shifting the ones ahead of it back
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            if (i == 0) begin
                rot_order[i] = order_at_p;
            end else if (CW'(i) <= p_sel) begin
                rot_order[i] = r_order[i - 1];
            end else begin
                rot_order[i] = r_order[i];
            end
        end
    end

    // Steer the shared comparator for the current step
    always_comb begin
        case (r_state)
            ST_SEARCH: begin
                cmp_a = tag_rd;
                cmp_b = r_addr;
            end
            ST_SCAN: begin
                cmp_a = tag_rd;
                cmp_b = r_best_tag;
            end
            ST_WB_MARK: begin
                cmp_a = r_mark;
                cmp_b = r_best_tag;
            end
            ST_BULK_MARK: begin
                cmp_a = r_mark;
                cmp_b = r_end;
            end
            default: begin
                cmp_a = r_mark;
                cmp_b = r_addr;
            end
        endcase
    end

    wbc_cmp #(
        .W (BB)
    ) u_cmp (
        .i_a   (cmp_a),
        .i_b   (cmp_b),
        .o_res (cmp_res)
    );

    // Scan step: keep the lowest dirty tag seen so far
    assign scan_take = r_dirty[idx_s] && (!r_found || cmp_res.lt);
    assign scan_last = (idx_s == SIW'(SLOTS - 1));

    // Flag the cycles in which a result enters the output register
    assign emit_now = o_free && ((r_state == ST_WB_EMIT) || (r_state == ST_DONE) ||
                                 ((r_state == ST_FILL_CHK) && !(r_mark_vld && cmp_res.lt)));

    // End block of a bulk write, before saturation
    assign bulk_sum = {1'b0, r_addr} + (BB + 1)'(r_cnt) - (BB + 1)'(1);

    // Tag store: written when a missing block takes a slot
    always_ff @(posedge i_clk) begin
        if (r_state == ST_INSERT) begin
            r_tag[order_at_p] <= r_addr;
        end
    end

    // Sequencer, policy state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_used     <= '0;
            r_dirty    <= '0;
            r_mark_vld <= 1'b0;
            r_mark     <= '0;
            r_ovalid   <= 1'b0;
            r_found    <= 1'b0;
            r_idx      <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_order[i] <= SIW'(SLOTS - 1 - i);
            end
        end else begin
            if (i_m_axis_tready && !emit_now) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_op    <= i_s_axis_tuser;
                        r_addr  <= BB'(i_s_axis_tdata[ADDR_W-1:0]);
                        r_cnt   <= i_s_axis_tdata[ADDR_W +: CNT_W];
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        if (i_s_axis_tuser inside {OP_READ, OP_WRITE}) begin
                            r_state <= ST_SEARCH;
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SEARCH: begin
                    if (r_idx == r_used) begin
                        if (r_used == CW'(SLOTS)) begin
                            r_idx   <= '0;
                            r_found <= 1'b0;
                            r_state <= ST_SCAN;
                        end else begin
                            r_state <= ST_INSERT;
                        end
                    end else if (cmp_res.eq) begin
                        r_order <= rot_order;
                        r_slot  <= order_at_p;
                        r_state <= ST_DONE;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                ST_SCAN: begin
                    if (scan_take) begin
                        r_best     <= idx_s;
                        r_best_tag <= tag_rd;
                        r_found    <= 1'b1;
                    end
                    if (scan_last) begin
                        if (r_found || scan_take) begin
                            r_state <= ST_WB_EMIT;
                        end else begin
                            case (r_op)
                                OP_FLUSH: begin
                                    r_state <= ST_DONE;
                                end
                                OP_BULK: begin
                                    r_used  <= '0;
                                    r_state <= (r_cnt != '0) ? ST_BULK_SUM : ST_DONE;
                                end
                                default: begin
                                    r_used  <= CW'(SLOTS - 1);
                                    r_state <= ST_INSERT;
                                end
                            endcase
                        end
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                ST_WB_EMIT: begin
                    if (o_free) begin
                        r_ovalid         <= 1'b1;
                        r_okind          <= KIND_WB;
                        r_oslot          <= SLOT_W'(r_best);
                        r_otgt           <= ADDR_W'(r_best_tag);
                        r_oad            <= 1'b0;
                        r_olast          <= 1'b0;
                        r_dirty[r_best]  <= 1'b0;
                        r_state          <= ST_WB_MARK;
                    end
                end
                ST_WB_MARK: begin
                    if (!r_mark_vld || cmp_res.lt) begin
                        r_mark     <= r_best_tag;
                        r_mark_vld <= 1'b1;
                    end
                    r_idx   <= '0;
                    r_found <= 1'b0;
                    r_state <= ST_SCAN;
                end
                ST_INSERT: begin
                    r_order <= rot_order;
                    r_slot  <= order_at_p;
                    r_used  <= r_used + CW'(1);
                    r_state <= ST_FILL_CHK;
                end
                ST_FILL_CHK: begin
                    if (r_mark_vld && cmp_res.lt) begin
                        r_state <= ST_DONE;
                    end else if (o_free) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= KIND_FILL;
                        r_oslot  <= SLOT_W'(r_slot);
                        r_otgt   <= ADDR_W'(r_addr);
                        r_oad    <= 1'b0;
                        r_olast  <= 1'b0;
                        r_state  <= ST_DONE;
                    end
                end
                ST_BULK_SUM: begin
                    r_end   <= bulk_sum[BB] ? '1 : bulk_sum[BB-1:0];
                    r_state <= ST_BULK_MARK;
                end
                ST_BULK_MARK: begin
                    if (!r_mark_vld || cmp_res.lt) begin
                        r_mark     <= r_end;
                        r_mark_vld <= 1'b1;
                    end
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (o_free) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= KIND_DONE;
                        r_olast  <= 1'b1;
                        r_oad    <= (r_op == OP_WRITE) ? r_dirty[r_slot] : 1'b0;
                        r_oslot  <= (r_op inside {OP_READ, OP_WRITE}) ? SLOT_W'(r_slot) : '0;
                        r_otgt   <= (r_op == OP_FLUSH) ? '0 : ADDR_W'(r_addr);
                        if (r_op == OP_WRITE) begin
                            r_dirty[r_slot] <= 1'b1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Drive the stream ports
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {{OUT_PAD{1'b0}}, r_oad, r_otgt, r_oslot};
    assign o_m_axis_tuser  = r_okind;
    assign o_m_axis_tlast  = r_olast;

    // Mark every slot that appears in the order list
    always_comb begin
        order_mask = '0;
        for (int i = 0; i < SLOTS; i++) begin
            order_mask[r_order[i]] = 1'b1;
        end
    end

    a_used_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(SLOTS))
        else $error("used count beyond slot count");

    a_order_perm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        order_mask == {SLOTS{1'b1}})
        else $error("slot order is not a permutation");

    a_wb_dirty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WB_EMIT) |-> r_dirty[r_best])
        else $error("write back chosen for a clean slot");

    a_last_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (o_m_axis_tuser == KIND_DONE)))
        else $error("tlast does not match done result");

    a_wb_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WB_EMIT && o_free) |=> !r_dirty[$past(r_best)])
        else $error("written-back slot still dirty");

endmodule
